>>> design/wts_pkg.sv
// ----------------------------------------------------------------------------
// wts_pkg
// Shared types, constants and helpers of the wavetable sound unit.
// ----------------------------------------------------------------------------
package wts_pkg;

  localparam int unsigned WAVE_MEM_DEPTH = 16384;
  localparam int unsigned WAVE_ADDR_W    = $clog2(WAVE_MEM_DEPTH);

  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Shared divider: 38-bit dividend, 17-bit divisor
  localparam int unsigned DIV_DVD_W = 38;
  localparam int unsigned DIV_DSR_W = 17;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_DVD_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_DVD_W - 1);

  localparam logic [21:0] DIV_CLOCK = 22'd3072000;
  localparam logic [24:0] STEP_MAX  = 25'h1FF_FFFF;

  localparam logic [2:0] FUNC_PWRITE = 3'd0;
  localparam logic [2:0] FUNC_MWRITE = 3'd1;
  localparam logic [2:0] FUNC_SWEEP  = 3'd2;
  localparam logic [2:0] FUNC_SAMPLE = 3'd3;
  localparam logic [2:0] FUNC_PREAD  = 3'd4;

  localparam logic CFG_SAMPLE_RATE  = 1'b0;
  localparam logic CFG_CHANNEL_MUTE = 1'b1;

  // Port register offsets from 0x80
  localparam logic [4:0] REG_SWEEP_DELTA  = 5'h0C;
  localparam logic [4:0] REG_SWEEP_PERIOD = 5'h0D;
  localparam logic [4:0] REG_NOISE_CTRL   = 5'h0E;
  localparam logic [4:0] REG_TABLE_BASE   = 5'h0F;
  localparam logic [4:0] REG_MODE         = 5'h10;
  localparam logic [4:0] REG_FORCED_MSB   = 5'h11;
  localparam logic [4:0] REG_NOISE_LO     = 5'h12;
  localparam logic [4:0] REG_NOISE_HI     = 5'h13;
  localparam logic [4:0] REG_VOICE_GAIN   = 5'h14;
  localparam logic [4:0] REG_VOICE_DATA   = 5'h09;

  localparam logic [7:0] NOISE_TAPS [8] = '{
    8'h03, 8'h33, 8'h1B, 8'h53, 8'h05, 8'h09, 8'h11, 8'h1D
  };

  typedef enum logic [2:0] {
    K_PWRITE = 3'd0,
    K_MWRITE = 3'd1,
    K_SWEEP  = 3'd2,
    K_SAMPLE = 3'd3,
    K_PREAD  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  port;
    logic [7:0]  data_byte;
    logic [13:0] ram_addr;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [7:0]         read_data;
  } out_item_t;

  typedef struct packed {
    kind_e                  kind;
    logic [4:0]             reg_idx;
    logic                   in_range;
    logic [7:0]             data;
    logic [WAVE_ADDR_W-1:0] addr;
  } cmd_t;

  // One clock of the selectable-length noise LFSR
  function automatic logic [15:0] noise_next(logic [15:0] s, logic [2:0] mode);
    logic [15:0] top;
    logic [15:0] mask;
    logic [15:0] v;
    top  = 16'h8000 >> mode;
    mask = top - 16'd1;
    v    = s & mask;
    if (v == 16'd0) begin
      v = mask;
    end
    if (^(v[7:0] & NOISE_TAPS[mode])) begin
      v = v | top;
    end
    return v >> 1;
  endfunction

endpackage

>>> design/wts_fifo.sv
// ----------------------------------------------------------------------------
// wts_fifo
// Short command queue between the decoder and the execution engine.
// ----------------------------------------------------------------------------
module wts_fifo import wts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_data_o
);

  cmd_t                  mem_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> design/wts_front.sv
// ----------------------------------------------------------------------------
// wts_front
// Accept input items, classify them and queue the ones that do work.
// ----------------------------------------------------------------------------
module wts_front import wts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  logic full;
  logic keep;
  cmd_t cmd;

  always_comb begin
    cmd.reg_idx  = in_item_i.port[4:0];
    cmd.in_range = (in_item_i.port[7:5] == 3'b100);
    cmd.data     = in_item_i.data_byte;
    cmd.addr     = in_item_i.ram_addr;
    cmd.kind     = K_PREAD;
    keep         = 1'b1;
    unique case (in_item_i.func)
      FUNC_PWRITE: begin
        cmd.kind = K_PWRITE;
        keep     = cmd.in_range;   // drop writes outside the port window
      end
      FUNC_MWRITE: cmd.kind = K_MWRITE;
      FUNC_SWEEP:  cmd.kind = K_SWEEP;
      FUNC_SAMPLE: cmd.kind = K_SAMPLE;
      FUNC_PREAD:  cmd.kind = K_PREAD;
      default:     keep = 1'b0;
    endcase
  end

  assign in_stall_o = full;

  wts_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && !full && keep),
    .push_data_i (cmd),
    .full_o      (full),
    .pop_i       (cmd_pop_i),
    .valid_o     (cmd_valid_o),
    .pop_data_o  (cmd_o)
  );

endmodule

>>> design/wts_div.sv
// ----------------------------------------------------------------------------
// wts_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wts_div import wts_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_DVD_W-1:0] dividend_i,
  input  logic [DIV_DSR_W-1:0] divisor_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [DIV_DVD_W-1:0] quotient_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DSR_W-1:0] dsr_q;
  logic [DIV_DSR_W-1:0] rem_q;
  logic [DIV_DVD_W-1:0] quo_q;
  logic [DIV_DSR_W:0]   trial;
  logic                 fits;

  assign trial = {rem_q, quo_q[DIV_DVD_W-1]};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? DIV_DSR_W'(trial - {1'b0, dsr_q}) : trial[DIV_DSR_W-1:0];
      quo_q <= {quo_q[DIV_DVD_W-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> design/wts_back.sv
// ----------------------------------------------------------------------------
// wts_back
// Execution engine: port registers, wave memory, phase, noise, sweep, mix.
// ----------------------------------------------------------------------------
module wts_back import wts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  input  logic [16:0] sample_rate_i,
  input  logic [3:0]  channel_mute_i,
  output logic        res_valid_o,
  output out_item_t   res_o,
  input  logic        res_ready_i
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_EXEC   = 10'b00_0000_0010,
    S_FREQ   = 10'b00_0000_0100,
    S_DIVA   = 10'b00_0000_1000,
    S_DIVB   = 10'b00_0001_0000,
    S_CH     = 10'b00_0010_0000,
    S_WAVE   = 10'b00_0100_0000,
    S_NOISE  = 10'b00_1000_0000,
    S_FINISH = 10'b01_0000_0000,
    S_SPARE  = 10'b10_0000_0000
  } state_e;

  state_e state_q;
  cmd_t   cmd_q;

  logic [7:0]  pb_q [32];
  logic [7:0]  pb_rd_q;
  logic [4:0]  pb_raddr;

  logic [7:0]             wave_mem [WAVE_MEM_DEPTH];
  logic [7:0]             mem_rd_q;
  logic [WAVE_ADDR_W-1:0] mem_raddr;
  logic                   mem_we;

  logic [15:0] frac_q [4];
  logic [24:0] step_q [4];
  logic [4:0]  pos_q  [4];
  logic [3:0]  gl_q   [4];
  logic [3:0]  gr_q   [4];
  logic [13:0] base_q [4];

  logic [7:0]         sweep_delta_q;
  logic [13:0]        sweep_period_q;
  logic signed [14:0] sweep_cnt_q;
  logic [15:0]        sweep_freq_q;
  logic [2:0]         noise_mode_q;
  logic [15:0]        noise_shift_q;
  logic [4:0]         vgl_q, vgr_q;

  logic [1:0]         ch_q;
  logic [1:0]         step_ch_q;
  logic [9:0]         noise_cnt_q;
  logic signed [15:0] acc_l_q, acc_r_q;

  logic                 div_start_q;
  logic [DIV_DVD_W-1:0] div_a_q;
  logic [DIV_DSR_W-1:0] div_b_q;
  logic                 div_busy, div_done;
  logic [DIV_DVD_W-1:0] div_q;

  // Per-cycle helpers
  logic [4:0]  r;
  logic [7:0]  v;
  logic [7:0]  mode;
  logic        live;
  logic [25:0] phase_sum;
  logic [4:0]  pos_new;
  logic [15:0] freq_word;
  logic [10:0] sweep_next;
  logic [3:0]  nib;

  logic               add_en;
  logic signed [8:0]  w_s;
  logic [4:0]         g_l, g_r;
  logic signed [14:0] prod_l, prod_r;

  function automatic logic signed [15:0] clamp16(logic signed [15:0] a);
    logic signed [17:0] x;
    x = {a, 2'b00};
    if (x > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (x < -18'sd32768) begin
      return -16'sh8000;
    end
    return x[15:0];
  endfunction

  assign r         = cmd_q.reg_idx;
  assign v         = cmd_q.data;
  assign mode      = pb_q[REG_MODE];
  assign live      = !channel_mute_i[ch_q];
  assign phase_sum = {10'b0, frac_q[ch_q]} + {1'b0, step_q[ch_q]};
  assign pos_new   = pos_q[ch_q] + phase_sum[20:16];
  assign freq_word = r[0] ? {v, pb_rd_q} : {pb_rd_q, v};
  assign sweep_next = sweep_freq_q[10:0] + {{3{sweep_delta_q[7]}}, sweep_delta_q};
  assign nib       = pos_q[ch_q][0] ? mem_rd_q[7:4] : mem_rd_q[3:0];

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign pb_raddr  = ((state_q == S_EXEC) && (cmd_q.kind == K_PWRITE)) ? (r ^ 5'd1) : r;
  assign mem_raddr = {base_q[ch_q][13:4], pos_new[4:1]};
  assign mem_we    = (state_q == S_EXEC) && (cmd_q.kind == K_MWRITE);

  // Channel contribution to the mix
  always_comb begin
    add_en = 1'b0;
    w_s    = '0;
    g_l    = {1'b0, gl_q[ch_q]};
    g_r    = {1'b0, gr_q[ch_q]};
    unique case (state_q)
      S_CH: begin
        if (ch_q == 2'd1 && mode[5]) begin
          add_en = live;
          w_s    = $signed({1'b0, pb_q[REG_VOICE_DATA]}) - 9'sd128;
          g_l    = vgl_q;
          g_r    = vgr_q;
        end
      end
      S_WAVE: begin
        add_en = live;
        w_s    = $signed({1'b0, nib, 4'b0000}) - 9'sd128;
      end
      S_NOISE: begin
        add_en = live && (noise_cnt_q == '0);
        w_s    = noise_shift_q[0] ? 9'sd127 : -9'sd128;
      end
      default: ;
    endcase
  end

  assign prod_l = $signed({1'b0, g_l}) * w_s;
  assign prod_r = $signed({1'b0, g_r}) * w_s;

  always_comb begin
    res_valid_o = (state_q == S_FINISH);
    if (cmd_q.kind == K_SAMPLE) begin
      res_o.result_kind  = 1'b0;
      res_o.left_sample  = clamp16(acc_l_q);
      res_o.right_sample = clamp16(acc_r_q);
      res_o.read_data    = 8'h00;
    end else begin
      res_o.result_kind  = 1'b1;
      res_o.left_sample  = '0;
      res_o.right_sample = '0;
      res_o.read_data    = cmd_q.in_range ? pb_rd_q : 8'h00;
    end
  end

  wts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wave_mem[cmd_q.addr] <= v;
    end
    mem_rd_q <= wave_mem[mem_raddr];
    pb_rd_q  <= pb_q[pb_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      cmd_q          <= '0;
      pb_q           <= '{default: '0};
      frac_q         <= '{default: '0};
      step_q         <= '{default: '0};
      pos_q          <= '{default: '0};
      gl_q           <= '{default: '0};
      gr_q           <= '{default: '0};
      base_q         <= '{default: '0};
      sweep_delta_q  <= '0;
      sweep_period_q <= '0;
      sweep_cnt_q    <= '0;
      sweep_freq_q   <= '0;
      noise_mode_q   <= '0;
      noise_shift_q  <= 16'd1;
      vgl_q          <= '0;
      vgr_q          <= '0;
      ch_q           <= '0;
      step_ch_q      <= '0;
      noise_cnt_q    <= '0;
      acc_l_q        <= '0;
      acc_r_q        <= '0;
      div_start_q    <= 1'b0;
      div_a_q        <= '0;
      div_b_q        <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (add_en) begin
        acc_l_q <= acc_l_q + {prod_l[14], prod_l};
        acc_r_q <= acc_r_q + {prod_r[14], prod_r};
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_IDLE;
          case (cmd_q.kind)
            K_PWRITE: begin
              pb_q[r] <= (r == REG_FORCED_MSB) ? (v | 8'h80) : v;
              unique case (r) inside
                [5'h00:5'h07]: state_q <= S_FREQ;
                [5'h08:5'h0B]: begin
                  gl_q[r[1:0]] <= v[7:4];
                  gr_q[r[1:0]] <= v[3:0];
                end
                REG_SWEEP_DELTA: sweep_delta_q <= v;
                REG_SWEEP_PERIOD: begin
                  sweep_period_q <= {9'(v) + 9'd1, 5'b00000};
                  sweep_cnt_q    <= $signed({1'b0, 9'(v) + 9'd1, 5'b00000});
                end
                REG_NOISE_CTRL: begin
                  noise_mode_q <= v[2:0];
                  if (v[3]) begin
                    noise_shift_q <= 16'd1;
                  end
                end
                REG_TABLE_BASE: begin
                  for (int i = 0; i < 4; i++) begin
                    base_q[i] <= {v, 2'(i), 4'b0000};
                  end
                end
                REG_VOICE_GAIN: begin
                  vgl_q <= {v[3:2], 3'b000};
                  vgr_q <= {v[1:0], 3'b000};
                end
                default: ;
              endcase
            end
            K_SWEEP: begin
              if (sweep_delta_q != 8'h00 && mode[6]) begin
                if (sweep_cnt_q[14]) begin
                  // reload, bend the channel 2 pitch and recompute its step
                  sweep_cnt_q  <= $signed({1'b0, sweep_period_q}) - 15'sd1;
                  sweep_freq_q <= {5'b0, sweep_next};
                  div_a_q      <= DIV_DVD_W'(DIV_CLOCK);
                  div_b_q      <= DIV_DSR_W'(12'd2048 - {1'b0, sweep_next});
                  step_ch_q    <= 2'd2;
                  div_start_q  <= 1'b1;
                  state_q      <= S_DIVA;
                end else begin
                  sweep_cnt_q <= sweep_cnt_q - 15'sd1;
                end
              end
            end
            K_SAMPLE: begin
              ch_q    <= '0;
              acc_l_q <= '0;
              acc_r_q <= '0;
              state_q <= S_CH;
            end
            K_PREAD: state_q <= S_FINISH;
            default: ;
          endcase
        end
        S_FREQ: begin
          state_q <= S_IDLE;
          if (r[2:1] == 2'd2) begin
            sweep_freq_q <= freq_word;
          end
          if (freq_word == 16'hFFFF) begin
            step_q[r[2:1]] <= '0;
          end else begin
            div_a_q     <= DIV_DVD_W'(DIV_CLOCK);
            div_b_q     <= DIV_DSR_W'(12'd2048 - {1'b0, freq_word[10:0]});
            step_ch_q   <= r[2:1];
            div_start_q <= 1'b1;
            state_q     <= S_DIVA;
          end
        end
        S_DIVA: begin
          if (div_done) begin
            div_a_q     <= {div_q[21:0], 16'h0000};
            div_b_q     <= sample_rate_i;
            div_start_q <= 1'b1;
            state_q     <= S_DIVB;
          end
        end
        S_DIVB: begin
          if (div_done) begin
            step_q[step_ch_q] <= (|div_q[DIV_DVD_W-1:25]) ? STEP_MAX : div_q[24:0];
            state_q           <= S_IDLE;
          end
        end
        S_CH: begin
          if (ch_q == 2'd1 && mode[5]) begin
            ch_q <= ch_q + 2'd1;
          end else if (mode[ch_q]) begin
            frac_q[ch_q] <= phase_sum[15:0];
            if (ch_q == 2'd3 && mode[7]) begin
              noise_cnt_q <= phase_sum[25:16];
              state_q     <= S_NOISE;
            end else begin
              pos_q[ch_q] <= pos_new;
              state_q     <= S_WAVE;
            end
          end else if (ch_q == 2'd3) begin
            state_q <= S_FINISH;
          end else begin
            ch_q <= ch_q + 2'd1;
          end
        end
        S_WAVE: begin
          if (ch_q == 2'd3) begin
            state_q <= S_FINISH;
          end else begin
            ch_q    <= ch_q + 2'd1;
            state_q <= S_CH;
          end
        end
        S_NOISE: begin
          if (noise_cnt_q != '0) begin
            noise_shift_q <= noise_next(noise_shift_q, noise_mode_q);
            noise_cnt_q   <= noise_cnt_q - 10'd1;
          end else begin
            pb_q[REG_NOISE_LO] <= noise_shift_q[7:0];
            pb_q[REG_NOISE_HI] <= {1'b0, noise_shift_q[14:8]};
            state_q            <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> !div_busy)
    else $error("divider started while busy");

  a_noise_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NOISE && noise_cnt_q != '0) |=> (state_q == S_NOISE))
    else $error("noise loop left early");

  a_pop_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q == S_EXEC))
    else $error("popped item not executed");
`endif

endmodule

>>> design/four_channel_wavetable_sound_unit_top.sv
// ----------------------------------------------------------------------------
// four_channel_wavetable_sound_unit_top
// Four-channel wavetable sound unit with noise, voice channel and sweep.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake            payload
//   in        input       in_valid / stall     in_item_i   (in_item_t)
//   out       output      out_valid / stall    out_item_o  (out_item_t)
//   cfg       input       cfg_valid / ready    cfg_index_i, cfg_data_i
//
// Wave memory writes, sweep ticks without reload and port writes are the
// shortest items, and a port read is longer. A frequency write and a sweep
// reload each make two 38-step passes through the shared divider.
// A sample tick also runs the noise loop once per noise LFSR step
// (up to 512 steps), so the noise loop sets the worst-case rate.
// Reset sets all control and sound state to defaults; wave memory is not cleared.
// A two-item queue decouples intake from execution, and an output register lets
// the engine hand off a result and go on while it waits on a stalled consumer.
// ----------------------------------------------------------------------------
module four_channel_wavetable_sound_unit_top import wts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  logic [16:0] sample_rate_q;
  logic [3:0]  channel_mute_q;

  logic      cmd_valid, cmd_pop;
  cmd_t      cmd;
  logic      res_valid, res_ready;
  out_item_t res;

  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  // Config writes are taken at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q  <= 17'd44100;
      channel_mute_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_RATE:  sample_rate_q  <= cfg_data_i;
        CFG_CHANNEL_MUTE: channel_mute_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  wts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  wts_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .sample_rate_i  (sample_rate_q),
    .channel_mute_i (channel_mute_q),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .res_ready_i    (res_ready)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> verif/four_channel_wavetable_sound_unit_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_wavetable_sound_unit_top_test
// Drives port writes, wave memory writes, sweep ticks, sample ticks, port reads
// and unused function codes into the sound unit. An in-line model predicts every sample and read.
// Each result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module four_channel_wavetable_sound_unit_top_test;
  import wts_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 700;
  // Table bases stay at 0x00 or 0x40, so the tables live in the first 128 bytes
  localparam int unsigned WAVE_FILL     = 128;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_item_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [16:0] cfg_data_i;

  four_channel_wavetable_sound_unit_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Sound model state, kept at the block's widths
  // --------------------------------------------------------------------------
  logic [16:0] m_rate;
  logic [3:0]  m_mute;
  logic [7:0]  m_ports [32];
  logic [7:0]  m_wave [WAVE_MEM_DEPTH];
  logic [15:0] m_frac [4];
  logic [24:0] m_step [4];
  logic [4:0]  m_pos [4];
  logic [3:0]  m_gl [4];
  logic [3:0]  m_gr [4];
  logic [13:0] m_base [4];
  logic [7:0]  m_sdelta;
  logic [13:0] m_speriod;
  int          m_scount;
  logic [15:0] m_sfreq;
  logic [2:0]  m_nmode;
  logic [15:0] m_nshift;
  logic [4:0]  m_vgl;
  logic [4:0]  m_vgr;

  out_item_t expected_results [$];
  int        fail_count;
  bit        hold_off;       // long receiver stall requested

  function automatic logic [24:0] step_for_hz(logic [31:0] hz);
    logic [63:0] q;
    if (m_rate == 0) begin
      return STEP_MAX;
    end
    q = {hz, 16'h0} / m_rate;
    return (q > STEP_MAX) ? STEP_MAX : q[24:0];
  endfunction

  function automatic logic [24:0] step_for_freq(logic [15:0] f);
    if (f == 16'hFFFF) begin
      return '0;
    end
    return step_for_hz(32'd3072000 / (32'd2048 - f[10:0]));
  endfunction

  task automatic predict_reset();
    m_rate = 17'd44100;
    m_mute = '0;
    foreach (m_ports[i]) m_ports[i] = '0;
    for (int c = 0; c < 4; c++) begin
      m_frac[c] = '0; m_step[c] = '0; m_pos[c] = '0;
      m_gl[c] = '0; m_gr[c] = '0; m_base[c] = '0;
    end
    m_sdelta = '0; m_speriod = '0; m_scount = 0; m_sfreq = '0;
    m_nmode = '0; m_nshift = 16'd1; m_vgl = '0; m_vgr = '0;
  endtask

  task automatic predict_port_write(logic [7:0] p, logic [7:0] v);
    logic [4:0] r;
    int         c;
    logic [15:0] f;
    if (p < 8'h80 || p > 8'h9F) begin
      return;
    end
    r = p[4:0];
    m_ports[r] = v;
    if (r <= 5'd7) begin
      c = r >> 1;
      f = {m_ports[c*2+1], m_ports[c*2]};
      if (c == 2) m_sfreq = f;
      m_step[c] = step_for_freq(f);
    end else if (r <= 5'd11) begin
      m_gl[r-8] = v[7:4];
      m_gr[r-8] = v[3:0];
    end else if (r == REG_SWEEP_DELTA) begin
      m_sdelta = v;
    end else if (r == REG_SWEEP_PERIOD) begin
      m_speriod = (14'(v) + 14'd1) << 5;
      m_scount = m_speriod;
    end else if (r == REG_NOISE_CTRL) begin
      m_nmode = v[2:0];
      if (v[3]) m_nshift = 16'd1;
    end else if (r == REG_TABLE_BASE) begin
      for (int k = 0; k < 4; k++) m_base[k] = 14'((v << 6) + 16 * k);
    end else if (r == REG_FORCED_MSB) begin
      m_ports[r] = v | 8'h80;
    end else if (r == REG_VOICE_GAIN) begin
      m_vgl = 5'((v & 8'h0C) * 2);
      m_vgr = 5'(((v << 2) & 8'h0C) * 2);
    end
  endtask

  task automatic predict_sweep();
    logic [15:0] d;
    if (m_sdelta == 0 || !m_ports[REG_MODE][6]) begin
      return;
    end
    if (m_scount < 0) begin
      d = {{8{m_sdelta[7]}}, m_sdelta};
      m_scount = m_speriod;
      m_sfreq = (m_sfreq + d) & 16'h07FF;
      m_step[2] = step_for_hz(32'd3072000 / (32'd2048 - m_sfreq));
    end
    m_scount--;
  endtask

  // Advance the noise LFSR by one clock.
  task automatic noise_clock();
    logic [15:0] top;
    logic [7:0]  taps;
    top = 16'h8000 >> m_nmode;
    case (m_nmode)
      3'd0: taps = 8'h03; 3'd1: taps = 8'h33; 3'd2: taps = 8'h1B; 3'd3: taps = 8'h53;
      3'd4: taps = 8'h05; 3'd5: taps = 8'h09; 3'd6: taps = 8'h11; default: taps = 8'h1D;
    endcase
    m_nshift = m_nshift & (top - 1);
    if (m_nshift == 0) m_nshift = top - 1;
    if (^(m_nshift[7:0] & taps)) m_nshift = m_nshift | top;
    m_nshift = m_nshift >> 1;
  endtask

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return -16'sh8000;
    return 16'(v);
  endfunction

  task automatic predict_sample(output out_item_t res);
    int          l, r, w;
    logic [7:0]  mode;
    logic [31:0] acc, cnt;
    logic [13:0] idx;
    logic [7:0]  b;
    bit          live;
    l = 0; r = 0;
    mode = m_ports[REG_MODE];
    for (int c = 0; c < 4; c++) begin
      live = !m_mute[c];
      if (c == 1 && mode[5]) begin
        w = int'(m_ports[REG_VOICE_DATA]) - 128;
        if (live) begin
          l += int'(m_vgl) * w; r += int'(m_vgr) * w;
        end
      end else if (mode[c]) begin
        acc = m_frac[c] + m_step[c];
        m_frac[c] = acc[15:0];
        cnt = acc >> 16;
        if (c == 3 && mode[7]) begin
          repeat (cnt) noise_clock();
          m_ports[REG_NOISE_LO] = m_nshift[7:0];
          m_ports[REG_NOISE_HI] = {1'b0, m_nshift[14:8]};
          w = m_nshift[0] ? 127 : -128;
        end else begin
          m_pos[c] = 5'(m_pos[c] + cnt);
          idx = (m_base[c] & 14'h3FF0) + m_pos[c][4:1];
          b = m_wave[idx];
          b = m_pos[c][0] ? (b & 8'hF0) : {b[3:0], 4'h0};
          w = int'(b) - 128;
        end
        if (live) begin
          l += int'(m_gl[c]) * w; r += int'(m_gr[c]) * w;
        end
      end
    end
    res = '0;
    res.left_sample  = clamp16(l * 4);
    res.right_sample = clamp16(r * 4);
  endtask

  task automatic predict_item(in_item_t it);
    out_item_t res;
    case (it.func)
      FUNC_PWRITE: predict_port_write(it.port, it.data_byte);
      FUNC_MWRITE: m_wave[it.ram_addr] = it.data_byte;
      FUNC_SWEEP:  predict_sweep();
      FUNC_SAMPLE: begin
        predict_sample(res);
        expected_results.push_back(res);
      end
      FUNC_PREAD: begin
        res = '0;
        res.result_kind = 1'b1;
        if (it.port >= 8'h80 && it.port <= 8'h9F) res.read_data = m_ports[it.port[4:0]];
        expected_results.push_back(res);
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sender: random gap, offer the item, hold it until accepted
  // --------------------------------------------------------------------------
  task automatic send_item(logic [2:0] func, logic [7:0] p, logic [7:0] d, logic [13:0] a);
    in_item_t it;
    int       gap;
    it.func = func; it.port = p; it.data_byte = d; it.ram_addr = a;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_item(it);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every expected result, let the engine drain, then write a register.
  task automatic write_config(logic idx, logic [16:0] v);
    drop_valid();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_SAMPLE_RATE) m_rate = v;
    else m_mute = v[3:0];
  endtask

  // Fill the table area reachable from the bases in use.
  task automatic fill_wave_memory();
    in_item_t it;
    for (int a = 0; a < WAVE_FILL; a++) begin
      it = in_item_t'{FUNC_MWRITE, 8'($urandom), 8'($urandom), 14'(a)};
      in_valid_i <= 1'b1;
      in_item_i  <= it;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      predict_item(it);
    end
    in_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls per item, plus a long hold-off on request
  // --------------------------------------------------------------------------
  task automatic check_result(out_item_t exp_r);
    if (out_item_o.result_kind !== exp_r.result_kind) begin
      $error("result_kind expected %0d actual %0d", exp_r.result_kind, out_item_o.result_kind);
      fail_count++;
    end
    if (out_item_o.left_sample !== exp_r.left_sample) begin
      $error("left_sample expected %0d actual %0d", exp_r.left_sample, out_item_o.left_sample);
      fail_count++;
    end
    if (out_item_o.right_sample !== exp_r.right_sample) begin
      $error("right_sample expected %0d actual %0d", exp_r.right_sample,
             out_item_o.right_sample);
      fail_count++;
    end
    if (out_item_o.read_data !== exp_r.read_data) begin
      $error("read_data expected %0h actual %0h", exp_r.read_data, out_item_o.read_data);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result %p", out_item_o);
          fail_count++;
        end else begin
          check_result(expected_results.pop_front());
        end
      end
    end
  end

  initial begin
    int wait_cycles;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rand_port();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'($urandom);
    if (sel <= 3) return 8'h80 + 8'($urandom_range(0, 7));
    return 8'h80 + 8'($urandom_range(0, 31));
  endfunction

  task automatic send_random_item();
    int         sel;
    logic [7:0] p;
    logic [7:0] d;
    sel = $urandom_range(0, 99);
    p   = rand_port();
    // keep the table bases inside the filled area
    d   = (p == {3'b100, REG_TABLE_BASE}) ? 8'($urandom_range(0, 1)) : 8'($urandom);
    if (sel < 35) send_item(FUNC_SAMPLE, 8'($urandom), 8'($urandom), 14'($urandom));
    else if (sel < 60) send_item(FUNC_PWRITE, p, d, 14'($urandom));
    else if (sel < 72) send_item(FUNC_PREAD, rand_port(), 8'($urandom), 14'($urandom));
    else if (sel < 85) send_item(FUNC_SWEEP, 8'($urandom), 8'($urandom), 14'($urandom));
    else if (sel < 95) send_item(FUNC_MWRITE, 8'($urandom), 8'($urandom), 14'($urandom));
    else send_item(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom), 14'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    // reads at reset, ports outside the range, forced bit 7 of 0x91
    send_item(FUNC_PREAD, 8'h80, 8'h00, 14'h0);
    send_item(FUNC_PWRITE, 8'h7F, 8'hFF, 14'h0);
    send_item(FUNC_PREAD, 8'h7F, 8'h00, 14'h0);
    send_item(FUNC_PREAD, 8'hFF, 8'h00, 14'h0);
    send_item(FUNC_PWRITE, 8'h91, 8'h01, 14'h0);
    send_item(FUNC_PREAD, 8'h91, 8'h00, 14'h0);
    send_item(FUNC_PWRITE, 8'h9F, 8'hA5, 14'h3FFF);
    send_item(FUNC_PREAD, 8'h9F, 8'h00, 14'h0);
    // all channels on, full gain on channel 0; silence frequency on channel 0
    send_item(FUNC_PWRITE, 8'h80, 8'hFF, 14'h0);
    send_item(FUNC_PWRITE, 8'h81, 8'hFF, 14'h0);
    send_item(FUNC_PWRITE, 8'h82, 8'hFF, 14'h0);
    send_item(FUNC_PWRITE, 8'h83, 8'h07, 14'h0);
    send_item(FUNC_PWRITE, 8'h88, 8'hFF, 14'h0);
    send_item(FUNC_PWRITE, 8'h89, 8'hF0, 14'h0);
    send_item(FUNC_PWRITE, 8'h90, 8'hFF, 14'h0);
    send_item(FUNC_SAMPLE, 8'h00, 8'h00, 14'h0);
    // voice mode, sweep, noise with reset bit
    send_item(FUNC_PWRITE, 8'h94, 8'h0F, 14'h0);
    send_item(FUNC_PWRITE, 8'h8C, 8'h80, 14'h0);
    send_item(FUNC_PWRITE, 8'h8D, 8'h00, 14'h0);
    send_item(FUNC_PWRITE, 8'h8E, 8'h0F, 14'h0);
    send_item(FUNC_PWRITE, 8'h86, 8'hFF, 14'h0);
    send_item(FUNC_PWRITE, 8'h87, 8'h07, 14'h0);
    repeat (3) send_item(FUNC_SWEEP, 8'h00, 8'h00, 14'h0);
    send_item(FUNC_SAMPLE, 8'h00, 8'h00, 14'h0);
    send_item(FUNC_PREAD, 8'h92, 8'h00, 14'h0);
    send_item(3'd7, 8'h80, 8'h55, 14'h0);
  endtask

  task automatic test_random(int n);
    repeat (n) send_random_item();
  endtask

  // Keep offering items while the receiver holds off so the queue backs up.
  task automatic test_backpressure();
    hold_off = 1'b1;
    repeat (12) send_item(FUNC_PREAD, rand_port(), 8'h00, 14'h0);
  endtask

  task automatic test_config_sweep();
    write_config(CFG_SAMPLE_RATE, 17'd8000);
    write_config(CFG_CHANNEL_MUTE, 17'd15);
    test_random(150);
    write_config(CFG_SAMPLE_RATE, 17'd96000);
    write_config(CFG_CHANNEL_MUTE, 17'd0);
    test_random(150);
    write_config(CFG_SAMPLE_RATE, 17'd0);
    write_config(CFG_CHANNEL_MUTE, 17'($urandom_range(1, 14)));
    test_random(150);
    write_config(CFG_SAMPLE_RATE, 17'h1FFFF);
    test_random(150);
    write_config(CFG_SAMPLE_RATE, 17'($urandom_range(8000, 96000)));
    write_config(CFG_CHANNEL_MUTE, 17'd0);
    test_random(160);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = 1'b0;
    cfg_data_i  = '0;
    fail_count  = 0;
    hold_off    = 1'b0;
    predict_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Write the table area first so no sample reads an unwritten entry.
    fill_wave_memory();
    test_directed();
    test_random(240);
    test_backpressure();
    test_config_sweep();

    drop_valid();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("four_channel_wavetable_sound_unit_top_test OK");
    end else begin
      $display("four_channel_wavetable_sound_unit_top_test NOT OK");
    end
    $finish;
  end

  // Timeout: ~1200 items at worst-case noise rate, settle pauses.
  initial begin
    #40ms;
    $display("four_channel_wavetable_sound_unit_top_test NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
design/wts_pkg.sv
design/wts_fifo.sv
design/wts_front.sv
design/wts_div.sv
design/wts_back.sv
design/four_channel_wavetable_sound_unit_top.sv
verif/four_channel_wavetable_sound_unit_top_test.sv
